>>> src/lfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

  // Packet length limit and the width of the frame counter.
  localparam int MaxFrames = 1024;
  localparam int CountW    = 11;

  // Register file of the configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_MODE   = 2'd0,
    REG_AUDIO_DELAY    = 2'd1,
    REG_FRAME_TIME_48K = 2'd2,
    REG_FRAME_TIME_44K = 2'd3
  } reg_idx_e;

  // Reset values of the registers.
  localparam logic [1:0] ChannelModeRst  = 2'd0;
  localparam logic [7:0] AudioDelayRst   = 8'd20;
  localparam logic [9:0] FrameTime48Rst  = 10'd480;
  localparam logic [9:0] FrameTime44Rst  = 10'd522;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DIRECT = 2'd1,
    CMD_FRAME  = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STEREO = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_MUTE   = 2'd3
  } mode_e;

  // LPCM header byte fields.
  localparam logic [7:0] HdrQuantMask  = 8'hC0;
  localparam logic [7:0] HdrRateMask   = 8'h30;
  localparam logic [7:0] HdrChanMask   = 8'h07;
  localparam logic [7:0] HdrRate48     = 8'h00;
  localparam logic [7:0] HdrRate44     = 8'h20;
  localparam logic [7:0] HdrChanStereo = 8'h01;

  // Timestamp offset: one delay step is 900 ticks, the neutral delay is 20.
  localparam int DelayStep = 900;
  localparam int DelayZero = 20;
  localparam logic [31:0] DelayBias = 32'(DelayStep * DelayZero);

  // Frame time has 8 fraction bits.
  localparam int FtFracW = 8;
  localparam int FtW     = 10;
  localparam int PlayW   = CountW + FtW;

  // Result queue geometry.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic               packet_end;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [CountW-1:0]  frame_count;
    logic               pts_valid;
    logic [31:0]        pts_out;
    logic               rate_44k;
  } result_t;

  // Queue writes of one accepted transaction: first and second result.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

>>> src/lfp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  header_byte;
  logic        direct_rate_44k;
  logic        pts_present;
  logic [31:0] pts_in;
  logic [31:0] frame_bytes;

  modport source (
    output valid, command, header_byte, direct_rate_44k, pts_present, pts_in, frame_bytes,
    input  ready
  );
  modport sink (
    input  valid, command, header_byte, direct_rate_44k, pts_present, pts_in, frame_bytes,
    output ready
  );
endinterface

interface lfp_out_if;
  logic               valid;
  logic               ready;
  logic               packet_end;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [10:0]        frame_count;
  logic               pts_valid;
  logic [31:0]        pts_out;
  logic               rate_44k;

  modport source (
    output valid, packet_end, left_sample, right_sample, frame_count, pts_valid, pts_out,
           rate_44k,
    input  ready
  );
  modport sink (
    input  valid, packet_end, left_sample, right_sample, frame_count, pts_valid, pts_out,
           rate_44k,
    output ready
  );
endinterface

`default_nettype wire

>>> src/lfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lfp_front
  import lfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  lfp_in_if.sink                   in_i,
  input  wire logic                room_i,
  output push_t                    push_o,
  output result_t                  res0_o,
  output result_t                  res1_o
);

  logic [1:0]        channel_mode_q;
  logic [7:0]        audio_delay_q;
  logic [FtW-1:0]    ft48_q;
  logic [FtW-1:0]    ft44_q;

  logic              stream_ok_q, stream_ok_d;
  logic              swap_q, swap_d;
  logic              stream_44k_q, stream_44k_d;
  logic              pkt_open_q, pkt_open_d;
  logic [CountW-1:0] frames_q, frames_d;
  logic              pkt_44k_q, pkt_44k_d;
  logic              pkt_ptsv_q, pkt_ptsv_d;
  logic [31:0]       pkt_pts_q, pkt_pts_d;
  logic              pend_ptsv_q, pend_ptsv_d;
  logic [31:0]       pend_pts_q, pend_pts_d;

  logic              accept;
  logic              hdr_ok;
  logic              hdr_44k;
  logic              attach;
  logic [17:0]       delay_ticks;
  logic [31:0]       pts_adj;
  logic [FtW-1:0]    ft_sel;
  logic [PlayW-1:0]  play_full;
  logic [31:0]       pts_back;
  logic [CountW-1:0] frames_open;
  logic [CountW-1:0] frames_next;
  logic              open_ptsv;
  logic [31:0]       open_pts;
  logic              open_44k;
  logic [15:0]       left_raw, right_raw;
  logic [15:0]       left_out, right_out;
  logic [7:0]        hb;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid && room_i;
  assign hb         = in_i.header_byte;

  assign hdr_44k = (hb & HdrRateMask) == HdrRate44;
  assign hdr_ok  = ((hb & HdrQuantMask) == 8'h00) && ((hb & HdrChanMask) == HdrChanStereo)
                   && (((hb & HdrRateMask) == HdrRate48) || hdr_44k);

  // Delay-adjusted timestamp, and its back-dated form for an open packet.
  assign delay_ticks = 18'(audio_delay_q) * 18'(DelayStep);
  assign pts_adj     = in_i.pts_in + 32'(delay_ticks) - DelayBias;
  assign ft_sel      = pkt_44k_q ? ft44_q : ft48_q;
  assign play_full   = PlayW'(frames_q) * PlayW'(ft_sel);
  assign pts_back    = pts_adj - 32'(play_full[PlayW-1:FtFracW]);

  // Packet state as seen by a frame, after opening a packet if none is open.
  assign frames_open = pkt_open_q ? frames_q : '0;
  assign frames_next = frames_open + CountW'(1);
  assign open_ptsv   = pkt_open_q ? pkt_ptsv_q : pend_ptsv_q;
  assign open_pts    = pkt_open_q ? pkt_pts_q : pend_pts_q;
  assign open_44k    = pkt_open_q ? pkt_44k_q : stream_44k_q;

  always_comb begin
    if (swap_q) begin
      left_raw  = {in_i.frame_bytes[7:0], in_i.frame_bytes[15:8]};
      right_raw = {in_i.frame_bytes[23:16], in_i.frame_bytes[31:24]};
    end else begin
      left_raw  = in_i.frame_bytes[15:0];
      right_raw = in_i.frame_bytes[31:16];
    end
    unique case (mode_e'(channel_mode_q))
      MODE_STEREO: begin
        left_out  = left_raw;
        right_out = right_raw;
      end
      MODE_LEFT: begin
        left_out  = left_raw;
        right_out = left_raw;
      end
      MODE_RIGHT: begin
        left_out  = right_raw;
        right_out = right_raw;
      end
      MODE_MUTE: begin
        left_out  = '0;
        right_out = '0;
      end
      default: begin
        left_out  = left_raw;
        right_out = right_raw;
      end
    endcase
  end

  always_comb begin
    stream_ok_d  = stream_ok_q;
    swap_d       = swap_q;
    stream_44k_d = stream_44k_q;
    pkt_open_d   = pkt_open_q;
    frames_d     = frames_q;
    pkt_44k_d    = pkt_44k_q;
    pkt_ptsv_d   = pkt_ptsv_q;
    pkt_pts_d    = pkt_pts_q;
    pend_ptsv_d  = pend_ptsv_q;
    pend_pts_d   = pend_pts_q;
    push_o       = '0;
    res0_o       = '0;
    res1_o       = '0;
    attach       = 1'b0;

    if (accept) begin
      unique case (cmd_e'(in_i.command))
        CMD_HEADER: begin
          stream_ok_d = hdr_ok;
          if (hdr_ok) begin
            swap_d       = 1'b1;
            stream_44k_d = hdr_44k;
            attach       = in_i.pts_present;
          end
        end
        CMD_DIRECT: begin
          stream_ok_d  = 1'b1;
          swap_d       = 1'b0;
          stream_44k_d = in_i.direct_rate_44k;
          attach       = in_i.pts_present && (in_i.pts_in != 32'd0);
        end
        CMD_FLUSH: begin
          if (pkt_open_q && (frames_q != '0)) begin
            push_o.first       = 1'b1;
            res0_o.packet_end  = 1'b1;
            res0_o.frame_count = frames_q;
            res0_o.pts_valid   = pkt_ptsv_q;
            res0_o.pts_out     = pkt_pts_q;
            res0_o.rate_44k    = pkt_44k_q;
            pkt_open_d         = 1'b0;
            frames_d           = '0;
            pkt_ptsv_d         = 1'b0;
            pkt_pts_d          = '0;
          end
        end
        CMD_FRAME: begin
          if (stream_ok_q) begin
            if (!pkt_open_q) begin
              pend_ptsv_d = 1'b0;
            end
            push_o.first        = 1'b1;
            res0_o.left_sample  = left_out;
            res0_o.right_sample = right_out;
            if (frames_next >= CountW'(MaxFrames)) begin
              push_o.second      = 1'b1;
              res1_o.packet_end  = 1'b1;
              res1_o.frame_count = frames_next;
              res1_o.pts_valid   = open_ptsv;
              res1_o.pts_out     = open_pts;
              res1_o.rate_44k    = open_44k;
              pkt_open_d         = 1'b0;
              frames_d           = '0;
              pkt_ptsv_d         = 1'b0;
              pkt_pts_d          = '0;
            end else begin
              pkt_open_d = 1'b1;
              frames_d   = frames_next;
              pkt_44k_d  = open_44k;
              pkt_ptsv_d = open_ptsv;
              pkt_pts_d  = open_pts;
            end
          end
        end
        default: begin
          stream_ok_d = stream_ok_q;
        end
      endcase

      if (attach) begin
        if (pkt_open_q) begin
          pkt_ptsv_d = 1'b1;
          pkt_pts_d  = pts_back;
        end else begin
          pend_ptsv_d = 1'b1;
          pend_pts_d  = pts_adj;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_mode_q <= ChannelModeRst;
      audio_delay_q  <= AudioDelayRst;
      ft48_q         <= FrameTime48Rst;
      ft44_q         <= FrameTime44Rst;
      stream_ok_q    <= 1'b0;
      swap_q         <= 1'b0;
      stream_44k_q   <= 1'b0;
      pkt_open_q     <= 1'b0;
      frames_q       <= '0;
      pkt_44k_q      <= 1'b0;
      pkt_ptsv_q     <= 1'b0;
      pkt_pts_q      <= '0;
      pend_ptsv_q    <= 1'b0;
      pend_pts_q     <= '0;
    end else begin
      stream_ok_q  <= stream_ok_d;
      swap_q       <= swap_d;
      stream_44k_q <= stream_44k_d;
      pkt_open_q   <= pkt_open_d;
      frames_q     <= frames_d;
      pkt_44k_q    <= pkt_44k_d;
      pkt_ptsv_q   <= pkt_ptsv_d;
      pkt_pts_q    <= pkt_pts_d;
      pend_ptsv_q  <= pend_ptsv_d;
      pend_pts_q   <= pend_pts_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_CHANNEL_MODE:   channel_mode_q <= cfg_data_i[1:0];
          REG_AUDIO_DELAY:    audio_delay_q  <= cfg_data_i[7:0];
          REG_FRAME_TIME_48K: ft48_q         <= cfg_data_i[FtW-1:0];
          REG_FRAME_TIME_44K: ft44_q         <= cfg_data_i[FtW-1:0];
          default:            channel_mode_q <= channel_mode_q;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lfp_queue
  import lfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire push_t   push_i,
  input  wire result_t wdata0_i,
  input  wire result_t wdata1_i,
  output logic         room_o,
  input  wire logic    pop_i,
  output logic         nonempty_o,
  output result_t      head_o
);

  result_t           slots_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic [QPtrW-1:0]  wr_ptr_next;
  logic [QCntW-1:0]  n_push;

  // Room is kept for the two results that one transaction can produce.
  assign room_o      = count_q <= QCntW'(QDepth - 2);
  assign nonempty_o  = count_q != '0;
  assign head_o      = slots_q[rd_ptr_q];
  assign wr_ptr_next = wr_ptr_q + QPtrW'(1);
  assign n_push      = QCntW'(push_i.first) + QCntW'(push_i.second);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(n_push);
    rd_ptr_d = pop_i ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q + n_push - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      slots_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_i.second) begin
      slots_q[wr_ptr_next] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> src/lfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lfp_back
  import lfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    nonempty_i,
  input  wire result_t head_i,
  output logic         pop_o,
  lfp_out_if.source    out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The output register reloads whenever it is empty or being taken.
  assign pop_o   = nonempty_i && (!valid_q || out_o.ready);
  assign valid_d = pop_o || (valid_q && !out_o.ready);

  assign out_o.valid        = valid_q;
  assign out_o.packet_end   = data_q.packet_end;
  assign out_o.left_sample  = data_q.left_sample;
  assign out_o.right_sample = data_q.right_sample;
  assign out_o.frame_count  = data_q.frame_count;
  assign out_o.pts_valid    = data_q.pts_valid;
  assign out_o.pts_out      = data_q.pts_out;
  assign out_o.rate_44k     = data_q.rate_44k;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

>>> src/lpcm_frame_packetizer.sv
// Channel   Dir  Width  Contents
// in_i      in   76     command, header_byte, direct_rate_44k, pts_present, pts_in, frame_bytes
// out_o     out  78     packet_end, left/right_sample, frame_count, pts_valid, pts_out, rate_44k
// cfg_*     in   13     write enable, 2-bit register index, 10-bit write data
//
// One input transaction is taken per cycle while the result queue has room for two results.
// A result is written into the queue at the edge that accepts its input transaction and is
// presented on out_o once the output register reloads; a frame that fills a packet yields two
// output transactions, drained one per cycle by the output register while the sink takes them.
// Reset clears the stream and packet state and loads the register defaults; there is no
// clearing pass. A stall on out_o fills the four-entry queue until fewer than two entries
// are free, then ready drops on in_i.
`timescale 1ns / 1ps
`default_nettype none

module lpcm_frame_packetizer
  import lfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  lfp_in_if.sink                   in_i,
  lfp_out_if.source                out_o
);

  // The front decodes each transaction against the stream and packet state and
  // produces up to two results: a sample, and a packet close when the packet fills
  // or on flush. Timestamps are adjusted by the audio delay and back-dated by the
  // play time of the frames already in an open packet.
  push_t   push;
  result_t res0;
  result_t res1;
  logic    room;
  logic    pop;
  logic    nonempty;
  result_t head;

  lfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .room_i     (room),
    .push_o     (push),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  // The queue decouples the front from output backpressure.
  lfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata0_i   (res0),
    .wdata1_i   (res1),
    .room_o     (room),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  // The back holds the presented result until the sink takes it.
  lfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nonempty_i (nonempty),
    .head_i     (head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
